/* rtl/lpd_pkg.sv */
// Shared types for the length-prefixed deframer.
// Used by lpd_core and length_prefixed_deframer_unit; depends on nothing.
package lpd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned TYPE_W = 16;
    localparam int unsigned LEN_W  = 16;

    // Position in the message: the four header bytes, then the payload.
    typedef enum logic [2:0] {
        HDR_TYPE_HI = 3'd0,
        HDR_TYPE_LO = 3'd1,
        HDR_LEN_HI  = 3'd2,
        HDR_LEN_LO  = 3'd3,
        IN_PAYLOAD  = 3'd4
    } lpd_state_t;

    // One step's outcome, from the parser to the output register.
    typedef struct packed {
        logic              valid;
        logic [TYPE_W-1:0] msg_type;
        logic [BYTE_W-1:0] payload_byte;
        logic              byte_valid;
        logic              last;
    } lpd_result_t;

endpackage

/* rtl/lpd_core.sv */
// Header parser and payload counter of the length-prefixed deframer.
// Depends on lpd_pkg for the state encoding and the result struct.
module lpd_core
    import lpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [BYTE_W-1:0] data_byte,
    output lpd_result_t       result
);

    lpd_state_t        state_reg, state_next;
    logic [TYPE_W-1:0] type_hold_reg, type_hold_next;
    logic [BYTE_W-1:0] length_high_reg, length_high_next;
    logic [LEN_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [LEN_W-1:0]  len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= HDR_TYPE_HI;
            type_hold_reg   <= '0;
            length_high_reg <= '0;
            bytes_left_reg  <= '0;
        end
        else if (step_en)
        begin
            state_reg       <= state_next;
            type_hold_reg   <= type_hold_next;
            length_high_reg <= length_high_next;
            bytes_left_reg  <= bytes_left_next;
        end
    end

    assign len = {length_high_reg, data_byte};

    always_comb
    begin
        state_next          = state_reg;
        type_hold_next      = type_hold_reg;
        length_high_next    = length_high_reg;
        bytes_left_next     = bytes_left_reg;
        result.valid        = 1'b0;
        result.msg_type     = type_hold_reg;
        result.payload_byte = '0;
        result.byte_valid   = 1'b0;
        result.last         = 1'b0;
        case (state_reg)
            HDR_TYPE_LO:
            begin
                type_hold_next = {type_hold_reg[TYPE_W-1:BYTE_W], data_byte};
                state_next     = HDR_LEN_HI;
            end
            HDR_LEN_HI:
            begin
                length_high_next = data_byte;
                state_next       = HDR_LEN_LO;
            end
            HDR_LEN_LO:
            begin
                if (len == '0)
                begin
                    // An empty message gives a lone marker result.
                    result.valid    = 1'b1;
                    result.last     = 1'b1;
                    bytes_left_next = '0;
                    state_next      = HDR_TYPE_HI;
                end
                else
                begin
                    bytes_left_next = len;
                    state_next      = IN_PAYLOAD;
                end
            end
            IN_PAYLOAD:
            begin
                result.valid        = 1'b1;
                result.payload_byte = data_byte;
                result.byte_valid   = 1'b1;
                if (bytes_left_reg <= LEN_W'(1))
                begin
                    result.last     = 1'b1;
                    bytes_left_next = '0;
                    state_next      = HDR_TYPE_HI;
                end
                else
                begin
                    bytes_left_next = bytes_left_reg - LEN_W'(1);
                end
            end
            default:
            begin
                // First header byte; unused codes are handled the same way.
                type_hold_next = {data_byte, {BYTE_W{1'b0}}};
                state_next     = HDR_TYPE_LO;
            end
        endcase
    end

    // The payload state always has at least one byte still to come.
    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == IN_PAYLOAD |-> bytes_left_reg != '0)
        else $error("payload state with zero bytes left");

    // The final payload byte, or an empty-message marker, sends the parser back to the header.
    a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && result.valid && result.last |=> state_reg == HDR_TYPE_HI)
        else $error("parser did not return to header after last result");

    // The parser never reaches one of the unused position codes.
    a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg <= IN_PAYLOAD)
        else $error("parser position out of range");

endmodule

/* rtl/length_prefixed_deframer_unit.sv */
// Top level of the length-prefixed deframer: input register, parser, result register.
// Depends on lpd_pkg and lpd_core.
//
//  Channel   Direction  Carries                           Accepted when
//  s_axis    in         data_byte (one stream byte)       s_axis_tvalid && s_axis_tready
//  m_axis    out        payload byte, type, valid, last   m_axis_tvalid && m_axis_tready
//
// An accepted item sits in the input register while the parser works on it;
// any result it causes is written to the output register when the parser
// steps on that item, and is offered on m_axis from that register.
// One item is accepted every cycle while the output side keeps taking results;
// the parser's state update is a single small counter step per byte.
// Header bytes produce no result; a payload byte or an empty-message marker
// produces exactly one. Reset (rst_n low, asynchronous) empties both registers
// and returns the parser to the first header byte.
// A stall on m_axis holds the pending result and the pending input byte; the
// input side stops taking items only while both are full.
module length_prefixed_deframer_unit
    import lpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] payload_byte
    output logic [TYPE_W:0]   m_axis_tuser,   // [15:0] msg_type, [16] byte_valid
    output logic              m_axis_tlast    // last_of_message
);

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    lpd_result_t       out_reg;
    lpd_result_t       step_result;
    logic              out_free;
    logic              step_en;
    logic              in_take;

    // The result register can take a new value when empty or being drained.
    assign out_free      = !out_valid_reg || m_axis_tready;
    // The parser advances on the held byte whenever its result has a place.
    assign step_en       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    lpd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .data_byte (in_byte_reg),
        .result    (step_result)
    );

    always_comb
    begin
        in_valid_next = in_take ? 1'b1 : (step_en ? 1'b0 : in_valid_reg);
        if (out_free)
        begin
            out_valid_next = step_en && step_result.valid;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (step_en && step_result.valid)
        begin
            out_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.payload_byte;
    assign m_axis_tuser  = {out_reg.byte_valid, out_reg.msg_type};
    assign m_axis_tlast  = out_reg.last;

    // An empty-message marker is always the last of its message and carries a zero byte.
    a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[TYPE_W] |-> m_axis_tlast && m_axis_tdata == '0)
        else $error("empty-message marker malformed");

    // A held input byte is not replaced while the parser is blocked.
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input byte lost while output stalled");

    // A result that is not taken stays on the output unchanged.
    a_output_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule
